// ===== rtl/shape_rasterizer_framebuffer_assert.svh =====
// Assertion macros shared by the rasteriser RTL.
`ifndef SHAPE_RASTERIZER_FRAMEBUFFER_ASSERT_SVH
`define SHAPE_RASTERIZER_FRAMEBUFFER_ASSERT_SVH

`ifndef SYNTHESIS
`define SRF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRF_ASSERT(lbl, clk, rst, prop, msg)
`define SRF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/srf_pkg.sv =====
`default_nettype none
package srf_pkg;

   localparam int REQ_TDATA_W = 80;
   localparam int REQ_TUSER_W = 5;
   localparam int RSP_TDATA_W = 8;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_DRAW  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [2:0] KIND_LINE   = 3'd1;
   localparam logic [2:0] KIND_RECT   = 3'd2;
   localparam logic [2:0] KIND_CIRCLE = 3'd3;
   localparam logic [2:0] KIND_TRI    = 3'd4;

   typedef enum logic [2:0] {
      OP_CLEAR, OP_LINE, OP_RECT, OP_CIRCLE, OP_TRI, OP_NONE, OP_READ
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE, S_CLEAR, S_LSETUP, S_LINE, S_CIRC, S_READ, S_READ_WAIT
   } state_type;

   typedef logic signed [10:0] pos_type;
   typedef logic signed [11:0] coord_type;

   typedef struct packed {
      op_type      op;
      pos_type     ax;
      pos_type     ay;
      pos_type     bx;
      pos_type     by;
      pos_type     tx;
      pos_type     ty;
      logic [9:0]  radius;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/shape_rasterizer_framebuffer.sv =====
// Clear sweeps the canvas one pixel row-major per cycle; a line is set up, then plotted;
// a circle plots each midpoint step's octant points; on-canvas reads wait on the RAM.
// Throughput: one word at a time in the raster engine, one plotted pixel per cycle
// through the single canvas RAM write port; a 2-word queue keeps the input side open.
// Reset: synchronous; after reset the whole canvas is swept blank before the first
// queued word is executed.
`default_nettype none
module shape_rasterizer_framebuffer #(
   parameter int CANVAS_WIDTH  = 80,
   parameter int CANVAS_HEIGHT = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata: start_x, start_y, end_x, end_y, third_x, third_y, radius, zero pad
   input  wire logic [srf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: action, kind
   input  wire logic [srf_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata: pixel_value, coord_inside, zero pad
   output logic [srf_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import srf_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // front end: decode and queue
   srf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // back end: raster engine, canvas RAM and result register
   srf_back #(
      .CANVAS_WIDTH (CANVAS_WIDTH),
      .CANVAS_HEIGHT(CANVAS_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== rtl/srf_ram.sv =====
`default_nettype none
module srf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1920
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/srf_front.sv =====
`default_nettype none
`include "shape_rasterizer_framebuffer_assert.svh"
module srf_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [srf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic [srf_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                  cmd_valid,
   output srf_pkg::cmd_type                      cmd,
   input  wire logic                             cmd_pop
);
   import srf_pkg::*;

   localparam logic [1:0] QDEPTH = 2'd2;

   cmd_type    dec;
   cmd_type    q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   // classify the incoming word
   always_comb begin
      dec.ax     = req_tdata[10:0];
      dec.ay     = req_tdata[21:11];
      dec.bx     = req_tdata[32:22];
      dec.by     = req_tdata[43:33];
      dec.tx     = req_tdata[54:44];
      dec.ty     = req_tdata[65:55];
      dec.radius = req_tdata[75:66];
      unique case (req_tuser[1:0])
         ACT_CLEAR: dec.op = OP_CLEAR;
         ACT_DRAW: begin
            unique case (req_tuser[4:2])
               KIND_LINE:   dec.op = OP_LINE;
               KIND_RECT:   dec.op = OP_RECT;
               KIND_CIRCLE: dec.op = OP_CIRCLE;
               KIND_TRI:    dec.op = OP_TRI;
               default:     dec.op = OP_NONE;
            endcase
         end
         ACT_READ: dec.op = OP_READ;
         default:  dec.op = OP_NONE;
      endcase
   end

   assign req_tready = (cnt_ff != QDEPTH);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd        = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = cmd_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `SRF_ASSERT(a_pop_needs_entry, clock, reset, cmd_pop |-> cmd_valid, "pop from empty queue")
   `SRF_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= QDEPTH, "queue count overflow")

endmodule
`default_nettype wire

// ===== rtl/srf_back.sv =====
`default_nettype none
`include "shape_rasterizer_framebuffer_assert.svh"
module srf_back #(
   parameter int CANVAS_WIDTH  = 80,
   parameter int CANVAS_HEIGHT = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             cmd_valid,
   input  srf_pkg::cmd_type                      cmd,
   output logic                                  cmd_pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [srf_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import srf_pkg::*;

   localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
   localparam coord_type WS = 12'(CANVAS_WIDTH);
   localparam coord_type HS = 12'(CANVAS_HEIGHT);

   typedef struct packed {
      pos_type x0;
      pos_type y0;
      pos_type x1;
      pos_type y1;
   } seg_type;

   function automatic seg_type seg_pts(input cmd_type c, input logic [1:0] s);
      seg_type p;
      p = '{x0: c.ax, y0: c.ay, x1: c.bx, y1: c.by};
      if (c.op == OP_RECT) begin
         case (s)
            2'd0:    p = '{x0: c.ax, y0: c.ay, x1: c.bx, y1: c.ay};
            2'd1:    p = '{x0: c.ax, y0: c.by, x1: c.bx, y1: c.by};
            2'd2:    p = '{x0: c.ax, y0: c.ay, x1: c.ax, y1: c.by};
            default: p = '{x0: c.bx, y0: c.ay, x1: c.bx, y1: c.by};
         endcase
      end else if (c.op == OP_TRI) begin
         case (s)
            2'd0:    p = '{x0: c.ax, y0: c.ay, x1: c.bx, y1: c.by};
            2'd1:    p = '{x0: c.bx, y0: c.by, x1: c.tx, y1: c.ty};
            default: p = '{x0: c.tx, y0: c.ty, x1: c.ax, y1: c.ay};
         endcase
      end
      return p;
   endfunction

   function automatic logic on_canvas(input coord_type x, input coord_type y);
      return (x >= 0) && (x < WS) && (y >= 0) && (y < HS);
   endfunction

   function automatic logic [AW-1:0] addr_of(input coord_type x, input coord_type y);
      logic [19:0] a;
      a = 20'(y[9:0]) * 20'(CANVAS_WIDTH) + 20'(x[9:0]);
      return a[AW-1:0];
   endfunction

   function automatic coord_type ext(input pos_type p);
      return {p[10], p};
   endfunction

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [1:0]        seg_ff, seg_in, nseg_ff, nseg_in;
   coord_type         lx_ff, lx_in, ly_ff, ly_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [11:0]       dx_ff, dx_in, dy_ff, dy_in;
   logic              sxn_ff, sxn_in, syn_ff, syn_in;
   logic signed [13:0] err_ff, err_in;
   coord_type         cx_ff, cx_in, cy_ff, cy_in, ox_ff, ox_in, oy_ff, oy_in;
   logic signed [15:0] d_ff, d_in;
   logic [2:0]        oct_ff, oct_in;
   logic              plot_v_ff, plot_v_in;
   coord_type         plot_x_ff, plot_x_in, plot_y_ff, plot_y_in;
   logic              rsp_v_ff, rsp_v_in, rsp_pix_ff, rsp_pix_in, rsp_ins_ff, rsp_ins_in;

   logic              wr_en, wr_data, rd_en, rd_data;
   logic [AW-1:0]     wr_addr, rd_addr;

   seg_type           sp;
   coord_type         x0, y0, x1, y1, dxs, dys, nx, ny;
   logic signed [14:0] e2;
   logic              stepx, stepy;
   logic signed [15:0] d_next;
   coord_type         dxy;
   coord_type         ox_next, oy_next;

   srf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // write port: clearing sweep has priority; otherwise the clipped plot stage
   always_comb begin
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = 1'b0;
      end else begin
         wr_en   = plot_v_ff && on_canvas(plot_x_ff, plot_y_ff);
         wr_addr = addr_of(plot_x_ff, plot_y_ff);
         wr_data = 1'b1;
      end
   end

   assign rd_addr    = addr_of(ext(cmd_ff.ax), ext(cmd_ff.ay));
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {6'd0, rsp_ins_ff, rsp_pix_ff};

   always_comb begin
      sp  = seg_pts(cmd_ff, seg_ff);
      x0  = ext(sp.x0);
      y0  = ext(sp.y0);
      x1  = ext(sp.x1);
      y1  = ext(sp.y1);
      dxs = x1 - x0;
      dys = y1 - y0;
      // Bresenham step decision on 2*err
      e2    = {err_ff, 1'b0};
      stepx = e2 > -$signed({3'b000, dy_ff});
      stepy = e2 < $signed({3'b000, dx_ff});
      nx    = sxn_ff ? lx_ff - 12'sd1 : lx_ff + 12'sd1;
      ny    = syn_ff ? ly_ff - 12'sd1 : ly_ff + 12'sd1;
      // midpoint decision; x - y is signed, so sign-extend before doubling
      dxy = ox_ff - oy_ff;
      if (d_ff < 0) begin
         d_next  = d_ff + $signed({3'b000, ox_ff[11:0], 1'b0}) + 16'sd3;
         oy_next = oy_ff;
      end else begin
         d_next  = d_ff + $signed({{3{dxy[11]}}, dxy, 1'b0}) + 16'sd5;
         oy_next = oy_ff - 12'sd1;
      end
      ox_next = ox_ff + 12'sd1;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      clr_rsp_in = clr_rsp_ff;
      clr_cnt_in = clr_cnt_ff;
      seg_in     = seg_ff;
      nseg_in    = nseg_ff;
      lx_in = lx_ff; ly_in = ly_ff; ex_in = ex_ff; ey_in = ey_ff;
      dx_in = dx_ff; dy_in = dy_ff; sxn_in = sxn_ff; syn_in = syn_ff;
      err_in = err_ff;
      cx_in = cx_ff; cy_in = cy_ff; ox_in = ox_ff; oy_in = oy_ff;
      d_in = d_ff; oct_in = oct_ff;
      plot_v_in  = 1'b0;
      plot_x_in  = plot_x_ff;
      plot_y_in  = plot_y_ff;
      rsp_v_in   = rsp_v_ff && !rsp_tready;
      rsp_pix_in = rsp_pix_ff;
      rsp_ins_in = rsp_ins_ff;
      cmd_pop    = 1'b0;
      rd_en      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_v_ff) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               seg_in  = 2'd0;
               unique case (cmd.op)
                  OP_CLEAR: begin
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  OP_LINE: begin
                     nseg_in  = 2'd0;
                     state_in = S_LSETUP;
                  end
                  OP_RECT: begin
                     nseg_in  = 2'd3;
                     state_in = S_LSETUP;
                  end
                  OP_TRI: begin
                     nseg_in  = 2'd2;
                     state_in = S_LSETUP;
                  end
                  OP_CIRCLE: begin
                     cx_in    = ext(cmd.ax);
                     cy_in    = ext(cmd.ay);
                     ox_in    = '0;
                     oy_in    = {2'b00, cmd.radius};
                     d_in     = 16'sd1 - $signed({6'd0, cmd.radius});
                     oct_in   = 3'd0;
                     state_in = S_CIRC;
                  end
                  OP_READ: state_in = S_READ;
                  default: begin
                     rsp_v_in   = 1'b1;
                     rsp_pix_in = 1'b0;
                     rsp_ins_in = 1'b0;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == ADDR_LAST) begin
               state_in = S_IDLE;
               if (clr_rsp_ff) begin
                  rsp_v_in   = 1'b1;
                  rsp_pix_in = 1'b0;
                  rsp_ins_in = 1'b0;
               end
            end
         end
         S_LSETUP: begin
            lx_in    = x0;
            ly_in    = y0;
            ex_in    = x1;
            ey_in    = y1;
            dx_in    = dxs[11] ? 12'(-dxs) : 12'(dxs);
            dy_in    = dys[11] ? 12'(-dys) : 12'(dys);
            sxn_in   = !(x0 < x1);
            syn_in   = !(y0 < y1);
            err_in   = $signed({2'b00, dx_in}) - $signed({2'b00, dy_in});
            state_in = S_LINE;
         end
         S_LINE: begin
            plot_v_in = 1'b1;
            plot_x_in = lx_ff;
            plot_y_in = ly_ff;
            if (lx_ff == ex_ff && ly_ff == ey_ff) begin
               if (seg_ff == nseg_ff) begin
                  state_in   = S_IDLE;
                  rsp_v_in   = 1'b1;
                  rsp_pix_in = 1'b0;
                  rsp_ins_in = 1'b0;
               end else begin
                  seg_in   = seg_ff + 2'd1;
                  state_in = S_LSETUP;
               end
            end else begin
               err_in = err_ff - (stepx ? $signed({2'b00, dy_ff}) : 14'sd0)
                               + (stepy ? $signed({2'b00, dx_ff}) : 14'sd0);
               if (stepx) lx_in = nx;
               if (stepy) ly_in = ny;
            end
         end
         S_CIRC: begin
            plot_v_in = 1'b1;
            case (oct_ff)
               3'd0: begin plot_x_in = cx_ff + ox_ff; plot_y_in = cy_ff + oy_ff; end
               3'd1: begin plot_x_in = cx_ff - ox_ff; plot_y_in = cy_ff + oy_ff; end
               3'd2: begin plot_x_in = cx_ff + ox_ff; plot_y_in = cy_ff - oy_ff; end
               3'd3: begin plot_x_in = cx_ff - ox_ff; plot_y_in = cy_ff - oy_ff; end
               3'd4: begin plot_x_in = cx_ff + oy_ff; plot_y_in = cy_ff + ox_ff; end
               3'd5: begin plot_x_in = cx_ff - oy_ff; plot_y_in = cy_ff + ox_ff; end
               3'd6: begin plot_x_in = cx_ff + oy_ff; plot_y_in = cy_ff - ox_ff; end
               default: begin plot_x_in = cx_ff - oy_ff; plot_y_in = cy_ff - ox_ff; end
            endcase
            oct_in = oct_ff + 3'd1;
            if (oct_ff == 3'd7) begin
               d_in  = d_next;
               ox_in = ox_next;
               oy_in = oy_next;
               if (ox_next > oy_next) begin
                  state_in   = S_IDLE;
                  rsp_v_in   = 1'b1;
                  rsp_pix_in = 1'b0;
                  rsp_ins_in = 1'b0;
               end
            end
         end
         S_READ: begin
            if (on_canvas(ext(cmd_ff.ax), ext(cmd_ff.ay))) begin
               rd_en    = 1'b1;
               state_in = S_READ_WAIT;
            end else begin
               state_in   = S_IDLE;
               rsp_v_in   = 1'b1;
               rsp_pix_in = 1'b0;
               rsp_ins_in = 1'b0;
            end
         end
         S_READ_WAIT: begin
            state_in   = S_IDLE;
            rsp_v_in   = 1'b1;
            rsp_pix_in = rd_data;
            rsp_ins_in = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_rsp_ff <= 1'b0;
         clr_cnt_ff <= '0;
         plot_v_ff  <= 1'b0;
         rsp_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_rsp_ff <= clr_rsp_in;
         clr_cnt_ff <= clr_cnt_in;
         plot_v_ff  <= plot_v_in;
         rsp_v_ff   <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      seg_ff <= seg_in; nseg_ff <= nseg_in;
      lx_ff <= lx_in; ly_ff <= ly_in; ex_ff <= ex_in; ey_ff <= ey_in;
      dx_ff <= dx_in; dy_ff <= dy_in; sxn_ff <= sxn_in; syn_ff <= syn_in;
      err_ff <= err_in;
      cx_ff <= cx_in; cy_ff <= cy_in; ox_ff <= ox_in; oy_ff <= oy_in;
      d_ff <= d_in; oct_ff <= oct_in;
      plot_x_ff <= plot_x_in; plot_y_ff <= plot_y_in;
      rsp_pix_ff <= rsp_pix_in; rsp_ins_ff <= rsp_ins_in;
   end

   `SRF_ASSERT(a_pop_when_free, clock, reset, cmd_pop |-> (state_ff == S_IDLE) && !rsp_v_ff, "pop while busy")
   `SRF_ASSERT(a_read_wait, clock, reset, (state_ff == S_READ_WAIT) |-> $past(rd_en), "read data without read")
   `SRF_ASSERT(a_wr_range, clock, reset, wr_en |-> (wr_addr <= ADDR_LAST), "write beyond canvas")

endmodule
`default_nettype wire
